// ----- rtl/ssba_pkg.sv -----
// Package for the swap slot bitmap allocator.
// Holds sizes, request and status codes, and the search result type.
// No dependencies.
`default_nettype none

package ssba_pkg;

   localparam int MAX_SLOTS        = 1024;
   localparam int SECTORS_PER_PAGE = 8;

   localparam int CFG_W    = 11;
   localparam int TYPE_W   = 2;
   localparam int SLOT_FW  = 10;
   localparam int STATUS_W = 2;
   localparam int SECT_W   = 13;

   localparam int SLOT_COUNT_RESET = 1024;

   localparam int WORD_W  = (MAX_SLOTS >= 32) ? 32 : 8;
   localparam int BIT_W   = $clog2(WORD_W);
   localparam int WORDS   = (MAX_SLOTS + WORD_W - 1) / WORD_W;
   localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int SLOT_W  = WADDR_W + BIT_W;
   localparam int EFF_W   = ($clog2(MAX_SLOTS + 1) > CFG_W) ? $clog2(MAX_SLOTS + 1) : CFG_W;
   localparam int CMP_W   = ((EFF_W > SLOT_W) ? EFF_W : SLOT_W) + 1;
   localparam int OFF_W   = (SECTORS_PER_PAGE > 1) ? $clog2(SECTORS_PER_PAGE) : 1;

   localparam logic [TYPE_W-1:0] REQ_SWAP_OUT = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_SWAP_IN  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_RELEASE  = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_UNUSED   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FREE      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_ASSIGNED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE        = 2'd3;

   typedef struct packed {
      logic             found;
      logic             final_word;
      logic [BIT_W-1:0] pos;
   } find_result_type;

endpackage

`default_nettype wire

// ----- rtl/ssba_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module ssba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                               rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/ssba_find.sv -----
// Free-slot search over one free map word: limit mask and lowest-set-bit encoder.
// Depends on ssba_pkg.
`default_nettype none

module ssba_find
   import ssba_pkg::*;
(
   input  wire logic [WADDR_W-1:0] word,
   input  wire logic [EFF_W-1:0]   limit,
   input  wire logic [WORD_W-1:0]  data,
   output find_result_type         result
);

   logic [CMP_W-1:0]  base;
   logic [CMP_W-1:0]  cnt;
   logic [CMP_W-1:0]  span;
   logic [WORD_W-1:0] mask;
   logic [WORD_W-1:0] hits;

   always_comb begin
      base = CMP_W'({word, {BIT_W{1'b0}}});
      cnt  = CMP_W'(limit);
      span = (cnt > base) ? (cnt - base) : '0;
      if (span >= CMP_W'(WORD_W)) begin
         mask = '1;
      end else begin
         mask = ~({WORD_W{1'b1}} << span);
      end
      hits = data & mask;
      result.found      = |hits;
      result.final_word = (span <= CMP_W'(WORD_W));
      result.pos        = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (hits[b]) begin
            result.pos = BIT_W'(b);
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/swap_slot_bitmap_allocator.sv -----
// Swap slot allocator top level: request sequencer, free map RAM and result register.
// Depends on ssba_pkg, ssba_ram and ssba_find.
//
// The free map sits in a RAM of 32-bit words, one bit per slot (1 = free),
// with one flip-flop per word marking it written; an unwritten word reads as
// all free, so no clearing pass runs after reset. A swap out scans the map
// word by word through one search unit, each word read and then checked,
// over up to 32 words. Swap in and release read one word, then check it; an
// out-of-range index answers straight from idle without a read. Results then
// leave at one per cycle while rsp_ready is high: eight sector commands for a
// page, one for a release or an error.
// The block takes one request at a time and accepts the next once the final
// result of the current one is taken. Request type 3 is dropped.
`default_nettype none

module swap_slot_bitmap_allocator
   import ssba_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [TYPE_W-1:0]   req_type,
   input  wire logic [SLOT_FW-1:0]  req_slot_index,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [SLOT_FW-1:0]       rsp_slot_used,
   output logic [SECT_W-1:0]        rsp_sector_number,
   output logic                     rsp_sector_write,
   output logic                     rsp_sector_valid,
   output logic                     rsp_last,
   input  wire logic                csr_write_en,
   input  wire logic [CFG_W-1:0]    csr_write_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_CHECK,
      S_RESP
   } state_type;

   state_type            state_ff, state_in;
   logic [CFG_W-1:0]     slot_count_ff, slot_count_in;
   logic [TYPE_W-1:0]    type_ff, type_in;
   logic [WADDR_W-1:0]   word_ff, word_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic [WORDS-1:0]     written_ff, written_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [SLOT_FW-1:0]   slot_used_ff, slot_used_in;
   logic [SECT_W-1:0]    sector_ff, sector_in;
   logic                 write_ff, write_in;
   logic                 svalid_ff, svalid_in;
   logic                 last_ff, last_in;
   logic [OFF_W-1:0]     off_ff, off_in;

   logic [EFF_W-1:0]     eff_count;
   logic [WORD_W-1:0]    ram_q;
   logic [WORD_W-1:0]    word_data;
   logic                 ram_wr_en;
   logic [WORD_W-1:0]    ram_wr_data;
   logic                 ram_rd_en;
   logic [SLOT_W-1:0]    idx_slot;
   logic [SLOT_W-1:0]    slot_sel;
   logic [SECT_W-1:0]    sector_base;
   find_result_type      find;

   ssba_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (word_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (word_ff),
      .rd_data (ram_q)
   );

   ssba_find u_find (
      .word   (word_ff),
      .limit  (eff_count),
      .data   (word_data),
      .result (find)
   );

   always_comb begin
      eff_count = (EFF_W'(slot_count_ff) > EFF_W'(MAX_SLOTS)) ? EFF_W'(MAX_SLOTS)
                                                              : EFF_W'(slot_count_ff);
      word_data   = written_ff[word_ff] ? ram_q : '1;
      idx_slot    = SLOT_W'(req_slot_index);
      slot_sel    = (type_ff == REQ_SWAP_OUT) ? {word_ff, find.pos} : {word_ff, bit_ff};
      sector_base = SECT_W'(32'(slot_sel) * 32'(SECTORS_PER_PAGE));
   end

   always_comb begin
      state_in      = state_ff;
      slot_count_in = csr_write_en ? csr_write_data : slot_count_ff;
      type_in       = type_ff;
      word_in       = word_ff;
      bit_in        = bit_ff;
      written_in    = written_ff;
      rsp_valid_in  = rsp_valid_ff;
      status_in     = status_ff;
      slot_used_in  = slot_used_ff;
      sector_in     = sector_ff;
      write_in      = write_ff;
      svalid_in     = svalid_ff;
      last_in       = last_ff;
      off_in        = off_ff;
      ram_wr_en     = 1'b0;
      ram_wr_data   = word_data;
      ram_rd_en     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_type != REQ_UNUSED) begin
               type_in      = req_type;
               slot_used_in = req_slot_index;
               if (req_type == REQ_SWAP_OUT) begin
                  word_in  = '0;
                  bit_in   = '0;
                  state_in = S_READ;
               end else if (EFF_W'(req_slot_index) >= eff_count) begin
                  status_in    = ST_RANGE;
                  sector_in    = '0;
                  write_in     = 1'b0;
                  svalid_in    = 1'b0;
                  last_in      = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = S_RESP;
               end else begin
                  word_in  = idx_slot[SLOT_W-1:BIT_W];
                  bit_in   = idx_slot[BIT_W-1:0];
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            ram_rd_en = 1'b1;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            status_in = ST_OK;
            sector_in = '0;
            write_in  = 1'b0;
            svalid_in = 1'b0;
            last_in   = 1'b1;
            off_in    = '0;
            if (type_ff == REQ_SWAP_OUT) begin
               if (find.found) begin
                  ram_wr_en           = 1'b1;
                  ram_wr_data         = word_data & ~(WORD_W'(1) << find.pos);
                  written_in[word_ff] = 1'b1;
                  bit_in              = find.pos;
                  slot_used_in        = SLOT_FW'(slot_sel);
                  sector_in           = sector_base;
                  write_in            = 1'b1;
                  svalid_in           = 1'b1;
                  last_in             = (SECTORS_PER_PAGE == 1);
                  rsp_valid_in        = 1'b1;
                  state_in            = S_RESP;
               end else if (find.final_word) begin
                  status_in    = ST_NO_FREE;
                  slot_used_in = '0;
                  rsp_valid_in = 1'b1;
                  state_in     = S_RESP;
               end else begin
                  word_in  = word_ff + WADDR_W'(1);
                  state_in = S_READ;
               end
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = S_RESP;
               if (word_data[bit_ff]) begin
                  status_in = ST_NOT_ASSIGNED;
               end else begin
                  ram_wr_en           = 1'b1;
                  ram_wr_data         = word_data | (WORD_W'(1) << bit_ff);
                  written_in[word_ff] = 1'b1;
                  if (type_ff == REQ_SWAP_IN) begin
                     sector_in = sector_base;
                     svalid_in = 1'b1;
                     last_in   = (SECTORS_PER_PAGE == 1);
                  end
               end
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               if (last_ff) begin
                  rsp_valid_in = 1'b0;
                  state_in     = S_IDLE;
               end else begin
                  sector_in = sector_ff + SECT_W'(1);
                  off_in    = off_ff + OFF_W'(1);
                  last_in   = ((off_ff + OFF_W'(1)) == OFF_W'(SECTORS_PER_PAGE - 1));
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slot_count_ff <= CFG_W'(SLOT_COUNT_RESET);
         written_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_count_ff <= slot_count_in;
         written_ff    <= written_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      type_ff      <= type_in;
      word_ff      <= word_in;
      bit_ff       <= bit_in;
      status_ff    <= status_in;
      slot_used_ff <= slot_used_in;
      sector_ff    <= sector_in;
      write_ff     <= write_in;
      svalid_ff    <= svalid_in;
      last_ff      <= last_in;
      off_ff       <= off_in;
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_slot_used     = slot_used_ff;
   assign rsp_sector_number = sector_ff;
   assign rsp_sector_write  = write_ff;
   assign rsp_sector_valid  = svalid_ff;
   assign rsp_last          = last_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a result is pending");

   a_resp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_RESP))
      else $error("result valid outside the response state");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> rsp_valid)
      else $error("sector run stopped before its last item");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_last && !rsp_sector_valid))
      else $error("error result carries a sector command");

endmodule

`default_nettype wire

// ----- bench/swap_slot_bitmap_allocator_tb.sv -----
// Testbench for the swap slot bitmap allocator: directed and random requests
// checked against a free-map predictor kept in a small scoreboard class.
// Depends on ssba_pkg and swap_slot_bitmap_allocator.
`timescale 1ns / 100ps

module swap_slot_bitmap_allocator_tb;
   import ssba_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_FW-1:0]  slot;
      logic [SECT_W-1:0]   sector;
      logic                wr;
      logic                sect_valid;
      logic                last;
   } swap_rsp_type;

   class swap_slot_scoreboard;
      bit               slot_free [MAX_SLOTS];
      logic [CFG_W-1:0] slot_count;
      swap_rsp_type     expected_q [$];
      int               errors;

      function new();
         foreach (slot_free[i]) slot_free[i] = 1'b1;
         slot_count = CFG_W'(SLOT_COUNT_RESET);
         errors     = 0;
      endfunction

      function int usable();
         return (slot_count > MAX_SLOTS) ? MAX_SLOTS : int'(slot_count);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function int pick_used();
         int used_q [$];
         for (int i = 0; i < usable(); i++)
            if (!slot_free[i]) used_q.push_back(i);
         if (used_q.size() == 0) return -1;
         return used_q[$urandom_range(0, used_q.size() - 1)];
      endfunction

      function void push_single(logic [STATUS_W-1:0] st, int slot);
         swap_rsp_type r;
         r            = '0;
         r.status     = st;
         r.slot       = SLOT_FW'(slot);
         r.last       = 1'b1;
         expected_q.push_back(r);
      endfunction

      function void push_sectors(int slot, logic wr);
         swap_rsp_type r;
         for (int k = 0; k < SECTORS_PER_PAGE; k++) begin
            r            = '0;
            r.status     = ST_OK;
            r.slot       = SLOT_FW'(slot);
            r.sector     = SECT_W'(slot * SECTORS_PER_PAGE + k);
            r.wr         = wr;
            r.sect_valid = 1'b1;
            r.last       = (k == SECTORS_PER_PAGE - 1);
            expected_q.push_back(r);
         end
      endfunction

      function void note_request(logic [TYPE_W-1:0] kind, logic [SLOT_FW-1:0] idx);
         int n;
         int s;
         n = usable();
         s = -1;
         case (kind)
            REQ_SWAP_OUT: begin
               for (int i = 0; i < n && s < 0; i++)
                  if (slot_free[i]) s = i;
               if (s < 0) begin
                  push_single(ST_NO_FREE, 0);
               end else begin
                  slot_free[s] = 1'b0;
                  push_sectors(s, 1'b1);
               end
            end
            REQ_SWAP_IN, REQ_RELEASE: begin
               if (int'(idx) >= n) begin
                  push_single(ST_RANGE, int'(idx));
               end else if (slot_free[idx]) begin
                  push_single(ST_NOT_ASSIGNED, int'(idx));
               end else begin
                  slot_free[idx] = 1'b1;
                  if (kind == REQ_SWAP_IN) push_sectors(int'(idx), 1'b0);
                  else push_single(ST_OK, int'(idx));
               end
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_result(swap_rsp_type got);
         swap_rsp_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected item, expected none, got %p", $time, got);
            return;
         end
         want = expected_q.pop_front();
         compare_field("status", 16'(want.status), 16'(got.status));
         compare_field("slot_used", 16'(want.slot), 16'(got.slot));
         compare_field("sector_number", 16'(want.sector), 16'(got.sector));
         compare_field("sector_write", 16'(want.wr), 16'(got.wr));
         compare_field("sector_valid", 16'(want.sect_valid), 16'(got.sect_valid));
         compare_field("last", 16'(want.last), 16'(got.last));
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [TYPE_W-1:0]   req_type;
   logic [SLOT_FW-1:0]  req_slot_index;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_FW-1:0]  rsp_slot_used;
   logic [SECT_W-1:0]   rsp_sector_number;
   logic                rsp_sector_write;
   logic                rsp_sector_valid;
   logic                rsp_last;
   logic                csr_write_en;
   logic [CFG_W-1:0]    csr_write_data;
   bit                  calm = 1'b0;

   swap_slot_scoreboard sb = new();

   swap_slot_bitmap_allocator u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_slot_index    (req_slot_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_slot_used     (rsp_slot_used),
      .rsp_sector_number (rsp_sector_number),
      .rsp_sector_write  (rsp_sector_write),
      .rsp_sector_valid  (rsp_sector_valid),
      .rsp_last          (rsp_last),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_request(input logic [TYPE_W-1:0] kind, input logic [SLOT_FW-1:0] idx);
      while (!calm && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_slot_index <= idx;
      do @(posedge clock); while (!req_ready);
      sb.note_request(kind, idx);
   endtask

   // drop the request, then drain all expected items
   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_slot_count(input logic [CFG_W-1:0] value);
      wait_quiet();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      sb.slot_count = value;
   endtask

   task automatic random_requests(input int count);
      logic [TYPE_W-1:0]  kind;
      logic [SLOT_FW-1:0] idx;
      int                 r;
      int                 u;
      repeat (count) begin
         r   = $urandom_range(0, 99);
         idx = SLOT_FW'($urandom);
         if (r < 45) begin
            kind = REQ_SWAP_OUT;
         end else if (r < 95) begin
            kind = (r < 72) ? REQ_SWAP_IN : REQ_RELEASE;
            u    = sb.pick_used();
            if (u >= 0 && $urandom_range(0, 99) < 80) idx = SLOT_FW'(u);
            else if ($urandom_range(0, 1)) idx = SLOT_FW'($urandom_range(0, 63));
         end else begin
            kind = REQ_UNUSED;
         end
         send_request(kind, idx);
      end
   endtask

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_type       <= REQ_SWAP_OUT;
      req_slot_index <= '0;
      csr_write_en   <= 1'b0;
      csr_write_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      write_slot_count(11'd2047);
      send_request(REQ_SWAP_IN, 10'd0);
      send_request(REQ_RELEASE, 10'd1023);
      send_request(REQ_SWAP_OUT, 10'd1023);
      send_request(REQ_SWAP_OUT, 10'd0);
      send_request(REQ_SWAP_OUT, 10'd0);
      send_request(REQ_UNUSED, 10'd1023);
      send_request(REQ_SWAP_IN, 10'd1);
      send_request(REQ_SWAP_OUT, 10'd0);
      send_request(REQ_RELEASE, 10'd0);
      send_request(REQ_RELEASE, 10'd0);
      send_request(REQ_SWAP_IN, 10'd2);

      write_slot_count(11'd0);
      send_request(REQ_SWAP_OUT, 10'd0);
      send_request(REQ_SWAP_IN, 10'd0);
      send_request(REQ_RELEASE, 10'd1023);

      write_slot_count(11'd1);
      send_request(REQ_SWAP_OUT, 10'd0);
      send_request(REQ_SWAP_OUT, 10'd0);
      send_request(REQ_RELEASE, 10'd1);

      write_slot_count(11'd1024);
      send_request(REQ_RELEASE, 10'd1);
      send_request(REQ_RELEASE, 10'd0);

      random_requests(60);
      calm = 1'b1;
      random_requests(50);
      calm = 1'b0;
      random_requests(30);

      write_slot_count(11'd12);
      random_requests(130);

      write_slot_count(11'd37);
      random_requests(100);

      wait_quiet();
      if (sb.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int taken;
      int hold_left;
      bit held;
      taken     = 0;
      hold_left = 0;
      held      = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            sb.check_result({rsp_status, rsp_slot_used, rsp_sector_number,
                             rsp_sector_write, rsp_sector_valid, rsp_last});
            taken++;
         end
         if (!held && taken >= 200) begin
            held      = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(0, 99) >= 33);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/ssba_pkg.sv
rtl/ssba_ram.sv
rtl/ssba_find.sv
rtl/swap_slot_bitmap_allocator.sv
bench/swap_slot_bitmap_allocator_tb.sv
